[hdl/assert_macros.svh]
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LIU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while in reset.
`define LIU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[hdl/liu_pkg.sv]
package liu_pkg;

    localparam int DEF_MAX_FACTOR  = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // width of the factor register as seen on the configuration port
    localparam int CFG_BITS = 5;

endpackage

[hdl/liu_div.sv]
// Restoring divider, one quotient bit per cycle.
module liu_div
    import liu_pkg::*;
#(
    parameter int DW = DEF_SAMPLE_BITS,
    parameter int FW = $clog2(DEF_MAX_FACTOR + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [FW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [FW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [DW-1:0] quo_reg,  quo_next;
    logic [FW-1:0] rem_reg,  rem_next;
    logic [FW-1:0] dsr_reg,  dsr_next;

    logic [FW:0]   trial;
    logic [FW:0]   trial_sub;
    logic          fits;

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the trial fits FW+1 bits
            rem_next = fits ? trial_sub[FW-1:0] : trial[FW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hdl/linear_interpolating_upsampler.sv]
// Results: after an input transaction the bit-serial divider runs first (ST_DIV), then
// results follow one per cycle while out_stall is low (ST_EMIT, then ST_LAST at a vector
// end); a lone sample goes straight to ST_LAST. Intake stalls from an accepted sample with
// a held predecessor or a vector end until its last result is issued.
// Reset (rst_n low, async): factor = 1, no sample held, output empty. No clearing pass.
module linear_interpolating_upsampler
    import liu_pkg::*;
#(
    parameter int MAX_FACTOR  = DEF_MAX_FACTOR,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          factor_valid,
    output logic                          factor_ready,
    input  logic [CFG_BITS-1:0]           factor,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          end_of_vector,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic                          run_end,
    output logic                          vector_end
);

    localparam int SB = SAMPLE_BITS;
    localparam int FW = $clog2(MAX_FACTOR + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_LAST = 2'd3;

    logic [1:0]          state_reg,     state_next;
    logic [CFG_BITS-1:0] factor_reg,    factor_next;
    logic                have_prev_reg, have_prev_next;
    logic [SB-1:0]       prev_reg,      prev_next;
    logic [SB-1:0]       cur_reg,       cur_next;
    logic                last_reg,      last_next;
    logic                neg_reg,       neg_next;
    logic [FW-1:0]       f_reg,         f_next;
    logic [FW-1:0]       k_reg,         k_next;
    logic [SB-1:0]       q_reg,         q_next;
    logic [FW-1:0]       r_reg,         r_next;
    logic                ov_reg,        ov_next;
    logic [SB-1:0]       oval_reg,      oval_next;
    logic                orun_reg,      orun_next;
    logic                ovec_reg,      ovec_next;

    logic          in_acc;
    logic          slot_free;
    logic [FW-1:0] eff_factor;
    logic [SB:0]   diff_w;
    logic [SB:0]   mag_w;
    logic          div_start;
    logic          div_done;
    logic [SB-1:0] dq;
    logic [FW-1:0] dr;
    logic [FW:0]   r_sum;
    logic [FW:0]   r_sub;
    logic          carry;
    logic [SB:0]   interp;
    logic          k_final;

    always_comb
    begin
        if (factor_reg == '0)
            eff_factor = FW'(1);
        else if (int'(factor_reg) > MAX_FACTOR)
            eff_factor = FW'(MAX_FACTOR);
        else
            eff_factor = FW'(factor_reg);
    end

    assign in_acc    = in_valid && (state_reg == ST_IDLE);
    assign slot_free = !ov_reg || !out_stall;
    assign diff_w    = {sample[SB-1], sample} - {prev_reg[SB-1], prev_reg};
    assign mag_w     = diff_w[SB] ? (~diff_w + (SB+1)'(1)) : diff_w;
    assign div_start = in_acc && have_prev_reg;

    liu_div #(
        .DW (SB),
        .FW (FW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_w[SB-1:0]),
        .divisor   (eff_factor),
        .done      (div_done),
        .quotient  (dq),
        .remainder (dr)
    );

    // |diff|*k = q*f + r, stepped by |diff| = dq*f + dr
    assign r_sum   = {1'b0, r_reg} + {1'b0, dr};
    assign r_sub   = r_sum - {1'b0, f_reg};
    assign carry   = (r_sum >= {1'b0, f_reg});
    assign interp  = neg_reg ? ({prev_reg[SB-1], prev_reg} - {1'b0, q_reg})
                             : ({prev_reg[SB-1], prev_reg} + {1'b0, q_reg});
    assign k_final = (k_reg == (f_reg - FW'(1)));

    always_comb
    begin
        state_next     = state_reg;
        factor_next    = factor_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        neg_next       = neg_reg;
        f_next         = f_reg;
        k_next         = k_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        ov_next        = ov_reg;
        oval_next      = oval_reg;
        orun_next      = orun_reg;
        ovec_next      = ovec_reg;

        if (factor_valid)
            factor_next = factor;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cur_next  = sample;
                    last_next = end_of_vector;
                    f_next    = eff_factor;
                    neg_next  = diff_w[SB];
                    if (!have_prev_reg)
                    begin
                        if (end_of_vector)
                            state_next = ST_LAST;
                        else
                        begin
                            prev_next      = sample;
                            have_prev_next = 1'b1;
                        end
                    end
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    q_next     = '0;
                    r_next     = '0;
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    oval_next = interp[SB-1:0];
                    orun_next = !last_reg && k_final;
                    ovec_next = 1'b0;
                    q_next    = q_reg + dq + SB'(carry);
                    r_next    = carry ? r_sub[FW-1:0] : r_sum[FW-1:0];
                    k_next    = k_reg + FW'(1);
                    if (k_final)
                    begin
                        if (last_reg)
                            state_next = ST_LAST;
                        else
                        begin
                            prev_next  = cur_reg;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_LAST:
            begin
                if (slot_free)
                begin
                    ov_next        = 1'b1;
                    oval_next      = cur_reg;
                    orun_next      = 1'b1;
                    ovec_next      = 1'b1;
                    have_prev_next = 1'b0;
                    prev_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            factor_reg    <= CFG_BITS'(1);
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            factor_reg    <= factor_next;
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        last_reg <= last_next;
        neg_reg  <= neg_next;
        f_reg    <= f_next;
        k_reg    <= k_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        oval_reg <= oval_next;
        orun_reg <= orun_next;
        ovec_reg <= ovec_next;
    end

    assign factor_ready = 1'b1;
    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = ov_reg;
    assign value        = oval_reg;
    assign run_end      = orun_reg;
    assign vector_end   = ovec_reg;

endmodule

[hdl/liu_chk.sv]
`include "assert_macros.svh"

module liu_chk
    import liu_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   end_of_vector,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_BITS-1:0] value,
    input logic                   run_end,
    input logic                   vector_end
);

    // the final output of a vector always closes the run of its input
    `LIU_ASSERT_IMP(a_vec_has_run, clk, rst_n, out_valid && vector_end, run_end)

    // a vector-ending transaction always produces results, so intake closes
    `LIU_ASSERT_NXT(a_eov_busy, clk, rst_n, in_valid && !in_stall && end_of_vector, in_stall)

    // while intake is open, only the closing result of a run can be pending
    `LIU_ASSERT_IMP(a_idle_pending, clk, rst_n, out_valid && !in_stall, run_end)

    // a stalled result holds
    `LIU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(value) && $stable(run_end) && $stable(vector_end))

endmodule

bind linear_interpolating_upsampler liu_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_liu_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .end_of_vector (end_of_vector),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .value         (value),
    .run_end       (run_end),
    .vector_end    (vector_end)
);
